### hdl/cau_pkg.sv
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int DEN_W     = 64;
  localparam int NUM_W     = 96;
  localparam int DIV_STEPS = 32;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 72;
  localparam int OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  // per-item result and flags carried alongside the datapath
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] rr;
    logic [WORD_W-1:0] ri;
    logic              eq;
    logic              ovf;
    logic              dz;
    logic              neg_r;
    logic              neg_i;
    logic              big_r;
    logic              big_i;
  } side_t;

  // 33-bit sum to saturated word; returns {ovf, word}
  function automatic logic [WORD_W:0] sat_add(input logic [WORD_W:0] s);
    logic [WORD_W:0] res;
    if (s[WORD_W] != s[WORD_W-1]) begin
      res = {1'b1, s[WORD_W] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else begin
      res = {1'b0, s[WORD_W-1:0]};
    end
    return res;
  endfunction

  // sign-magnitude to saturated word; returns {ovf, word}
  function automatic logic [WORD_W:0] sat_sm(input logic neg, input logic [DEN_W-1:0] mag);
    logic [WORD_W:0] res;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        res = {1'b1, 32'h8000_0000};
      end else begin
        res = {1'b0, 32'(~mag[WORD_W-1:0] + 32'd1)};
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        res = {1'b1, 32'h7FFF_FFFF};
      end else begin
        res = {1'b0, mag[WORD_W-1:0]};
      end
    end
    return res;
  endfunction

endpackage

### hdl/cau_div.sv
module cau_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [cau_pkg::NUM_W-1:0]   num,
  input  logic [cau_pkg::DEN_W-1:0]   den,
  output logic [cau_pkg::WORD_W-1:0]  quot
);
  import cau_pkg::*;

  logic [NUM_W-1:0]  rem_r [DIV_STEPS];
  logic [DEN_W-1:0]  den_r [DIV_STEPS];
  logic [WORD_W-1:0] q_r   [DIV_STEPS];

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [WORD_W-1:0] q_in;
    logic [NUM_W-1:0]  dsh;
    logic              take;
    logic [NUM_W-1:0]  rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign dsh     = NUM_W'(den_in) << (DIV_STEPS - 1 - k);
    assign take    = rem_in >= dsh;
    assign rem_nxt = take ? rem_in - dsh : rem_in;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        q_r[k]   <= {q_in[WORD_W-2:0], take};
      end
    end
  end

  assign quot = q_r[DIV_STEPS-1];

endmodule

### hdl/complex_arith_unit.sv
// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide
// (a * conj(b) / |b|^2) and compare equal, with truncation toward zero and
// saturation. One transaction is accepted per clock while the output buffer has room.
// The registers on the way are the operand register, the multiply, combine and
// prepare stages, the 32-stage restoring divider (one quotient bit per stage) and
// the output buffer; final saturation sits in front of the buffer. A two-entry
// output buffer keeps input flowing while one result waits; the pipeline holds
// only when both entries are full.
module complex_arith_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a_real[31:0], a_imag[63:32], b_real[95:64], b_imag[127:96]
  input  logic [cau_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation[2:0]
  input  logic [cau_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_real[31:0], result_imag[63:32], are_equal[64], overflowed[65],
  // divided_by_zero[66], zero pad [71:67]
  output logic [cau_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import cau_pkg::*;

  localparam int NS = DIV_STEPS + 4;

  logic [NS-1:0] v_r;
  logic [1:0]    cnt_r;
  logic          en;

  assign en        = cnt_r != 2'd2;
  assign in_tready = en;

  // stage 0: operand register
  logic [OP_W-1:0]   op0_r;
  logic [WORD_W-1:0] ar0_r, ai0_r, br0_r, bi0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= in_tuser;
      ar0_r <= in_tdata[31:0];
      ai0_r <= in_tdata[63:32];
      br0_r <= in_tdata[95:64];
      bi0_r <= in_tdata[127:96];
    end
  end

  // stage 1: products, add/sub/compare
  logic signed [63:0] p_rr1_r, p_ii1_r, p_ri1_r, p_ir1_r, p_b1_r, p_b2_r;
  side_t              side1_nxt, side1_r;
  logic [WORD_W:0]    sr, si;

  always_comb begin
    side1_nxt    = '0;
    side1_nxt.op = op0_r;
    sr = '0;
    si = '0;
    case (op_t'(op0_r))
      OP_ADD: begin
        sr = sat_add({ar0_r[31], ar0_r} + {br0_r[31], br0_r});
        si = sat_add({ai0_r[31], ai0_r} + {bi0_r[31], bi0_r});
      end
      OP_SUB: begin
        sr = sat_add({ar0_r[31], ar0_r} - {br0_r[31], br0_r});
        si = sat_add({ai0_r[31], ai0_r} - {bi0_r[31], bi0_r});
      end
      OP_CMP: side1_nxt.eq = (ar0_r == br0_r) && (ai0_r == bi0_r);
      default: ;
    endcase
    side1_nxt.rr  = sr[WORD_W-1:0];
    side1_nxt.ri  = si[WORD_W-1:0];
    side1_nxt.ovf = sr[WORD_W] | si[WORD_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr1_r <= $signed(ar0_r) * $signed(br0_r);
      p_ii1_r <= $signed(ai0_r) * $signed(bi0_r);
      p_ri1_r <= $signed(ar0_r) * $signed(bi0_r);
      p_ir1_r <= $signed(ai0_r) * $signed(br0_r);
      p_b1_r  <= $signed(br0_r) * $signed(br0_r);
      p_b2_r  <= $signed(bi0_r) * $signed(bi0_r);
      side1_r <= side1_nxt;
    end
  end

  // stage 2: combine partial products
  logic signed [64:0] x2_r, y2_r;
  logic [DEN_W-1:0]   den2_r;
  side_t              side2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (op_t'(side1_r.op) == OP_MUL) begin
        x2_r <= {p_rr1_r[63], p_rr1_r} - {p_ii1_r[63], p_ii1_r};
        y2_r <= {p_ri1_r[63], p_ri1_r} + {p_ir1_r[63], p_ir1_r};
      end else begin
        x2_r <= {p_rr1_r[63], p_rr1_r} + {p_ii1_r[63], p_ii1_r};
        y2_r <= {p_ir1_r[63], p_ir1_r} - {p_ri1_r[63], p_ri1_r};
      end
      den2_r  <= 64'(p_b1_r) + 64'(p_b2_r);
      side2_r <= side1_r;
    end
  end

  // stage 3: sign-magnitude, multiply saturation, divider setup
  logic [DEN_W-1:0]  mag_x, mag_y, shx, shy;
  logic [64:0]       neg_x65, neg_y65;
  logic [NUM_W-1:0]  num_x, num_y, den_top;
  logic [WORD_W:0]   mr, mi;
  side_t             side3_nxt, side3_r;
  logic [NUM_W-1:0]  num_r3_r, num_i3_r;
  logic [DEN_W-1:0]  den3_r;

  always_comb begin
    neg_x65 = 65'(-x2_r);
    neg_y65 = 65'(-y2_r);
    mag_x   = x2_r[64] ? neg_x65[63:0] : x2_r[63:0];
    mag_y   = y2_r[64] ? neg_y65[63:0] : y2_r[63:0];
    shx     = mag_x >> FRAC_BITS;
    shy     = mag_y >> FRAC_BITS;
    num_x   = NUM_W'(mag_x) << FRAC_BITS;
    num_y   = NUM_W'(mag_y) << FRAC_BITS;
    den_top = NUM_W'(den2_r) << WORD_W;
    mr      = sat_sm(x2_r[64] && (shx != '0), shx);
    mi      = sat_sm(y2_r[64] && (shy != '0), shy);
    side3_nxt = side2_r;
    side3_nxt.neg_r = x2_r[64];
    side3_nxt.neg_i = y2_r[64];
    side3_nxt.big_r = num_x >= den_top;
    side3_nxt.big_i = num_y >= den_top;
    case (op_t'(side2_r.op))
      OP_MUL: begin
        side3_nxt.rr  = mr[WORD_W-1:0];
        side3_nxt.ri  = mi[WORD_W-1:0];
        side3_nxt.ovf = mr[WORD_W] | mi[WORD_W];
      end
      OP_DIV: side3_nxt.dz = den2_r == '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r  <= side3_nxt;
      num_r3_r <= num_x;
      num_i3_r <= num_y;
      den3_r   <= den2_r;
    end
  end

  // stages 4 .. 35: dividers, side info alongside
  logic [WORD_W-1:0] q_re, q_im;
  side_t             side_d_r [DIV_STEPS];

  cau_div u_div_re (
    .clk  (clk),
    .en   (en),
    .num  (num_r3_r),
    .den  (den3_r),
    .quot (q_re)
  );

  cau_div u_div_im (
    .clk  (clk),
    .en   (en),
    .num  (num_i3_r),
    .den  (den3_r),
    .quot (q_im)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= side3_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        side_d_r[k] <= side_d_r[k-1];
      end
    end
  end

  // final saturation and select
  side_t             sf;
  logic [WORD_W:0]   dr, di;
  logic [OUT_DATA_W-1:0] res;

  always_comb begin
    sf = side_d_r[DIV_STEPS-1];
    dr = sat_sm(sf.neg_r, sf.big_r ? '1 : DEN_W'(q_re));
    di = sat_sm(sf.neg_i, sf.big_i ? '1 : DEN_W'(q_im));
    if (op_t'(sf.op) == OP_DIV && !sf.dz) begin
      res = {5'b0, sf.dz, dr[WORD_W] | di[WORD_W], sf.eq,
             di[WORD_W-1:0], dr[WORD_W-1:0]};
    end else begin
      res = {5'b0, sf.dz, sf.ovf, sf.eq, sf.ri, sf.rr};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_tvalid};
    end
  end

  // two-entry output buffer
  logic [OUT_DATA_W-1:0] ent0_r, ent1_r;
  logic                  push, pop;

  assign push       = en && v_r[NS-1];
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = ent0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case (cnt_r)
        2'd0: if (push) cnt_r <= 2'd1;
        2'd1: if (push && !pop) cnt_r <= 2'd2;
              else if (!push && pop) cnt_r <= 2'd0;
        2'd2: if (pop) cnt_r <= 2'd1;
        default: cnt_r <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cnt_r)
      2'd0: if (push) ent0_r <= res;
      2'd1: begin
        if (push && pop) ent0_r <= res;
        else if (push) ent1_r <= res;
      end
      2'd2: if (pop) ent0_r <= ent1_r;
      default: ;
    endcase
  end

endmodule

### hdl/cau_checker.sv
module cau_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cau_pkg::OUT_DATA_W-1:0]   out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:67] == 5'b0)
    else $error("pad bits set");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66] |-> out_tdata[65:0] == 66'b0)
    else $error("divide by zero result not clean");

  a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> out_tdata[63:0] == 64'b0 && !out_tdata[65])
    else $error("compare result carries data");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cau_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ar;
    logic [31:0] ai;
    logic [31:0] br;
    logic [31:0] bi;
  } cx_item_t;

  typedef struct packed {
    logic [31:0] rr;
    logic [31:0] ri;
    logic        eq;
    logic        ovf;
    logic        dz;
  } cx_res_t;

  localparam int LATENCY   = 37;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 1600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  complex_arith_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  cx_item_t pending_items[$];
  cx_res_t  expected_results[$];
  int mismatches = 0;
  int cycle = 0;
  int n_sent = 0;
  int n_checked = 0;
  int op_seen[8];
  bit quiet = 1'b0;       // no idling in the last stretch
  bit hold_send = 1'b0;   // sender pause until drained
  int in_gap = 0;
  int out_gap = 0;

  // sign-magnitude to saturated word
  function automatic logic [31:0] sat_mag(input bit neg, input logic [127:0] mag,
                                          inout bit ovf);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 128'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic logic [31:0] sat_signed(input logic signed [127:0] v, inout bit ovf);
    return sat_mag(v < 0, v < 0 ? -v : v, ovf);
  endfunction

  // truncated-toward-zero product part
  function automatic logic [31:0] mul_part(input logic signed [127:0] v, inout bit ovf);
    logic [127:0] mag;
    mag = (v < 0 ? -v : v) >> FRAC_BITS;
    return sat_mag(v < 0 && mag != 0, mag, ovf);
  endfunction

  function automatic logic [31:0] div_part(input logic signed [127:0] num,
                                           input logic [127:0] den, inout bit ovf);
    logic [127:0] q;
    bit neg;
    neg = num < 0;
    q = ((neg ? -num : num) << FRAC_BITS) / den;
    if (q > 128'hFFFF_FFFF) begin
      ovf = 1'b1;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return sat_mag(neg, q, ovf);
  endfunction

  function automatic cx_res_t predict_complex(input cx_item_t it);
    cx_res_t r;
    logic signed [127:0] ar, ai, br, bi;
    logic [127:0] den;
    bit ovf;
    r = '0;
    ovf = 1'b0;
    ar = $signed(it.ar); ai = $signed(it.ai);
    br = $signed(it.br); bi = $signed(it.bi);
    case (it.op)
      OP_ADD: begin
        r.rr = sat_signed(ar + br, ovf);
        r.ri = sat_signed(ai + bi, ovf);
      end
      OP_SUB: begin
        r.rr = sat_signed(ar - br, ovf);
        r.ri = sat_signed(ai - bi, ovf);
      end
      OP_MUL: begin
        r.rr = mul_part(ar * br - ai * bi, ovf);
        r.ri = mul_part(ar * bi + ai * br, ovf);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.rr = div_part(ar * br + ai * bi, den, ovf);
          r.ri = div_part(ai * br - ar * bi, den, ovf);
        end
      end
      OP_CMP: r.eq = (it.ar == it.br) && (it.ai == it.bi);
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 511)) - 256) << $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic cx_item_t rand_item();
    cx_item_t it;
    it.op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
    it.ar = rand_word(); it.ai = rand_word();
    it.br = rand_word(); it.bi = rand_word();
    if ($urandom_range(0, 9) == 0) begin
      it.br = it.ar;
      it.bi = ($urandom_range(0, 1) != 0) ? it.ai : it.ai ^ (32'h1 << $urandom_range(0, 31));
    end
    if (it.op == OP_DIV && $urandom_range(0, 19) == 0) begin
      it.br = '0; it.bi = '0;
    end
    return it;
  endfunction

  task automatic add_item(input logic [2:0] op, input logic [31:0] ar, ai, br, bi);
    cx_item_t it;
    it.op = op; it.ar = ar; it.ai = ai; it.br = br; it.bi = bi;
    pending_items.push_back(it);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_tready) begin
        // hold the transaction
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 3);
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_send) begin
        cx_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.op;
        in_tdata <= {it.bi, it.br, it.ai, it.ar};
      end else begin
        in_tvalid <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && in_tvalid && in_tready) begin
      cx_item_t it;
      it = {in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64], in_tdata[127:96]};
      expected_results.push_back(predict_complex(it));
      op_seen[it.op]++;
      n_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      cx_res_t got, exp_r;
      got = {out_tdata[31:0], out_tdata[63:32], out_tdata[64], out_tdata[65], out_tdata[66]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (got !== exp_r || out_tdata[71:67] !== 5'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp rr=%h ri=%h eq=%b ovf=%b dz=%b, got rr=%h ri=%h eq=%b ovf=%b dz=%b",
                     n_checked, exp_r.rr, exp_r.ri, exp_r.eq, exp_r.ovf, exp_r.dz,
                     got.rr, got.ri, got.eq, got.ovf, got.dz);
        end
      end
    end
    if (cycle > MAX_CYCLE) begin
      $display("timeout at cycle %0d", cycle);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] ext[4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed: extremes under each operation, divide by zero, equality, bad codes
    for (int op = 0; op < 5; op++) begin
      add_item(3'(op), ext[0], ext[1], ext[1], ext[0]);
      add_item(3'(op), ext[0], ext[0], ext[0], ext[0]);
      add_item(3'(op), ext[1], ext[3], 32'h0001_0000, ext[3]);
    end
    add_item(OP_DIV, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
    add_item(OP_DIV, ext[1], ext[0], 32'h0, 32'h1);
    add_item(OP_CMP, 32'h1234_5678, 32'h9, 32'h1234_5678, 32'h8);
    add_item(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
    add_item(3'd5, ext[1], ext[1], ext[1], ext[1]);
    add_item(3'd6, ext[0], ext[3], 32'h0, 32'h1);
    add_item(3'd7, ext[3], ext[3], ext[3], ext[3]);
    wait (pending_items.size() == 0);
    for (int i = 0; i < N_RANDOM / 2; i++) pending_items.push_back(rand_item());
    wait (pending_items.size() == 0);
    // drain fully before sending more
    hold_send = 1'b1;
    wait (expected_results.size() == 0);
    @(negedge clk);
    hold_send = 1'b0;
    for (int i = 0; i < N_RANDOM / 2; i++) pending_items.push_back(rand_item());
    wait (pending_items.size() < 200);
    quiet = 1'b1;
    wait (pending_items.size() == 0);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d transactions, checked %0d results", n_sent, n_checked);
    $display("ops add/sub/mul/div/cmp/undef: %0d/%0d/%0d/%0d/%0d/%0d", op_seen[0],
             op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5] + op_seen[6] + op_seen[7]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/cau_pkg.sv
hdl/cau_div.sv
hdl/complex_arith_unit.sv
hdl/cau_checker.sv
tb/testbench.sv
